>>> rtl/mcp_pkg.sv
package mcp_pkg;

  // Field widths.
  localparam int SIZE_W = 48;
  localparam int IDX_W = 3;
  localparam int CNT_W = 4;
  localparam int DES_W = 4;
  localparam int STRAT_W = 2;

  // Divisor of the spacing division is at most seven, so three bits.
  localparam int DIV_W = 3;
  localparam int DIV_CNT_W = $clog2(SIZE_W);

  // Fixed limits.
  localparam int RESULT_LIMIT = 8;
  localparam int SPARE_RESERVE = 64;
  localparam int GEO_N = 5;

  // Default parameter values.
  localparam int DEF_SECTORS_PER_COPY = 8;
  localparam int DEF_MIN_COPIES = 2;
  localparam int DEF_COPY_CEILING = 8;

  localparam logic [DES_W-1:0] DESIRED_RESET = 4'd5;
  localparam logic [SIZE_W-1:0] GEO_STEP = 48'd1024;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_NO_SPACE = 1'b1;

  // Fixed geometric copy positions.
  localparam logic [SIZE_W-1:0] GEO_POS [GEO_N] = '{
    48'd0, 48'd1024, 48'd2048, 48'd4096, 48'd8192
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_COUNT,
    ST_DIV,
    ST_EMIT
  } st_t;

  typedef enum logic [STRAT_W-1:0] {
    STRAT_GEOMETRIC,
    STRAT_LINEAR,
    STRAT_MINIMAL,
    STRAT_CUSTOM
  } strat_t;

  typedef enum logic [0:0] {
    REG_DESIRED_COPIES
  } reg_idx_t;

  // Status of the serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Geometric position for a copy index; indexes past the table read zero.
  function automatic logic [SIZE_W-1:0] geo_at(input logic [IDX_W-1:0] idx);
    logic [SIZE_W-1:0] val;
    val = '0;
    if (idx < IDX_W'(GEO_N)) begin
      val = GEO_POS[idx];
    end
    return val;
  endfunction

endpackage

>>> rtl/metadata_copy_placement_core.sv
// Metadata copy placement. Given the size of a spare device in sectors on the
// input channel (in_valid, in_ready, spare_sectors), the block returns one beat
// per metadata copy on the output channel (out_valid, out_ready and fields),
// with last set on the final beat. A size too small for a copy plus the
// reserve gives a single beat with status set to no space.
// The APB port holds the desired copy count (register 0); write it only while
// the block is idle. pready is always high and reads return the register.
// One item is handled at a time: in_ready is high only when idle.
// out_valid rises after a setup state for the no-space and geometric cases;
// packed copies first pass the copy counter, which adds one sector span per
// cycle, and evenly spread copies then also pass the serial divider that
// makes one quotient bit per cycle over 48 bits. After that one beat leaves
// per cycle while out_ready is high; a stalled receiver holds the current
// beat unchanged. in_ready rises right after the last beat is taken. Reset
// returns to idle, drops any item in progress and sets the desired copy
// count to 5.
module metadata_copy_placement_core
  import mcp_pkg::*;
#(
  parameter int SECTORS_PER_COPY = DEF_SECTORS_PER_COPY,
  parameter int MIN_COPIES = DEF_MIN_COPIES,
  parameter int COPY_CEILING = DEF_COPY_CEILING
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SIZE_W-1:0]  spare_sectors,
  // Output channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [IDX_W-1:0]   copy_index,
  output logic [SIZE_W-1:0]  copy_sector,
  output logic [CNT_W-1:0]   copy_count,
  output logic [STRAT_W-1:0] strategy,
  output logic               last
);

  localparam int COPY_CAP = (COPY_CEILING < RESULT_LIMIT) ? COPY_CEILING : RESULT_LIMIT;
  localparam logic [DES_W-1:0]  CAP_D    = DES_W'(COPY_CAP);
  localparam logic [CNT_W-1:0]  MIN_N    = CNT_W'(MIN_COPIES);
  localparam logic [SIZE_W-1:0] SEC      = SIZE_W'(SECTORS_PER_COPY);
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(SECTORS_PER_COPY + SPARE_RESERVE);

  st_t               state;
  st_t               state_next;

  logic [DES_W-1:0]  desired;
  logic [DES_W-1:0]  d_clamp;

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] acc;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  n;
  logic [IDX_W-1:0]  idx;
  logic [SIZE_W-1:0] pos;
  logic [SIZE_W-1:0] step;
  logic              fail;
  logic              geo_mode;

  logic              cfg_wr;
  logic              in_acc;
  logic              out_acc;
  logic              too_small;
  logic              geo_ok;
  logic [CNT_W-1:0]  gcnt;
  logic [SIZE_W:0]   acc_sum;
  logic              more;
  logic              lin_ok;
  logic              is_last;
  logic              div_start;
  div_stat_t         div_stat;
  logic [SIZE_W-1:0] div_q;
  strat_t            strat_v;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      desired <= DESIRED_RESET;
    end else if (cfg_wr && (paddr[2] == REG_DESIRED_COPIES)) begin
      desired <= pwdata[DES_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_DESIRED_COPIES) begin
      prdata = {{(32 - DES_W){1'b0}}, desired};
    end
  end

  // Desired count limited to one through the copy cap.
  always_comb begin
    d_clamp = desired;
    if (d_clamp == '0) begin
      d_clamp = DES_W'(1);
    end
    if (d_clamp > CAP_D) begin
      d_clamp = CAP_D;
    end
  end

  // Geometric positions that fit, counted in table order.
  always_comb begin
    gcnt = '0;
    for (int i = 0; i < GEO_N; i++) begin
      if ((({1'b0, GEO_POS[i]} + {1'b0, SEC}) <= {1'b0, size_r}) &&
          (gcnt == CNT_W'(i))) begin
        gcnt = gcnt + 1'b1;
      end
    end
  end

  assign too_small = size_r < MIN_SIZE;
  assign geo_ok    = gcnt >= MIN_N;

  // Copy counter: one more copy while it fits and more are wanted.
  assign acc_sum = {1'b0, acc} + {1'b0, SEC};
  assign more    = (k < d_clamp) && (acc_sum <= {1'b0, size_r});
  assign lin_ok  = (k >= MIN_N) && (k >= CNT_W'(2));

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign is_last = (({1'b0, idx}) + CNT_W'(1)) == n;

  // Spacing divider: (size - sectors per copy) / (copies - 1).
  mcp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (size_r - SEC),
    .divisor  (DIV_W'(k - CNT_W'(1))),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (too_small || geo_ok) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (!more) begin
          state_next = lin_ok ? ST_DIV : ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && is_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake and sequencer outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_SETUP: ;
      ST_COUNT: div_start = !more && lin_ok;
      ST_DIV:   ;
      ST_EMIT:  out_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          size_r <= spare_sectors;
        end
      end
      ST_SETUP: begin
        idx      <= '0;
        pos      <= '0;
        acc      <= '0;
        k        <= '0;
        fail     <= too_small;
        geo_mode <= !too_small && geo_ok;
        n        <= too_small ? CNT_W'(1) : gcnt;
      end
      ST_COUNT: begin
        if (more) begin
          acc <= acc_sum[SIZE_W-1:0];
          k   <= k + 1'b1;
        end else begin
          n    <= k;
          step <= SEC;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          step <= (div_q < SEC) ? SEC : div_q;
        end
      end
      ST_EMIT: begin
        if (out_acc && !is_last) begin
          idx <= idx + 1'b1;
          pos <= geo_mode ? geo_at(idx + 1'b1) : pos + step;
        end
      end
      default: ;
    endcase
  end

  // Strategy that the emitted positions match.
  always_comb begin
    if (fail) begin
      strat_v = STRAT_GEOMETRIC;
    end else if (n < CNT_W'(2)) begin
      strat_v = STRAT_MINIMAL;
    end else if (geo_mode) begin
      strat_v = STRAT_GEOMETRIC;
    end else if ((step == GEO_STEP) && (n <= CNT_W'(3))) begin
      strat_v = STRAT_GEOMETRIC;
    end else begin
      strat_v = STRAT_LINEAR;
    end
  end

  // Result fields.
  assign status      = fail ? STATUS_NO_SPACE : STATUS_OK;
  assign copy_index  = idx;
  assign copy_sector = pos;
  assign copy_count  = fail ? '0 : n;
  assign strategy    = strat_v;
  assign last        = is_last;

  // A beat that is not the last is followed by another beat.
  a_beats_follow: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid)
    else $error("result sequence ended before its last beat");

  // A no-space result is a single, empty beat.
  a_no_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last && (copy_count == '0) && (copy_index == '0))
    else $error("no-space result is not a single empty beat");

  // A placement beat always indexes within the placed copies.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> (copy_count != '0) && ({1'b0, copy_index} < copy_count))
    else $error("copy index outside the placed copy count");

  // The divider runs and finishes only while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (div_stat.busy || div_stat.done) |-> (state == ST_DIV))
    else $error("divider active outside the divide step");

endmodule

>>> rtl/mcp_div.sv
module mcp_div
  import mcp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [DIV_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [SIZE_W-1:0] quotient
);

  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     dvs;
  logic [SIZE_W-1:0]    quo;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DIV_W:0]       trial;
  logic [DIV_W:0]       diff;
  logic                 ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial = {rem, quo[SIZE_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // Control: one quotient bit per cycle, MSB first.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SIZE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Data path: the quotient bits replace the dividend bits as they shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[SIZE_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> tb/sv/tb_metadata_copy_placement_core.sv
module tb_metadata_copy_placement_core;
  import mcp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SPAN = DEF_SECTORS_PER_COPY;
  localparam int unsigned FLOOR_COPIES = DEF_MIN_COPIES;
  localparam int unsigned COPY_CAP =
    (DEF_COPY_CEILING < RESULT_LIMIT) ? DEF_COPY_CEILING : RESULT_LIMIT;
  localparam longint unsigned GEO_SITES [5] = '{0, 1024, 2048, 4096, 8192};
  localparam logic [2:0] DESIRED_ADDR = 3'(4 * REG_DESIRED_COPIES);
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES = 8;
  localparam int SIZES_PER_PHASE = 9;

  // One expected output beat.
  typedef struct {
    logic               status;
    logic [IDX_W-1:0]   idx;
    logic [SIZE_W-1:0]  sector;
    logic [CNT_W-1:0]   count;
    strat_t             strat;
    logic               last;
  } copy_beat_t;

  // Predicts the copy placement for each accepted size and checks the beats.
  class copy_placement_tracker;
    copy_beat_t pending_copies[$];
    logic [DES_W-1:0] desired;
    int errors;

    function new();
      desired = DESIRED_RESET;
      errors = 0;
    endfunction

    function void set_desired(logic [DES_W-1:0] value);
      desired = value;
    endfunction

    function int pending();
      return pending_copies.size();
    endfunction

    function void note_size(logic [SIZE_W-1:0] size);
      longint unsigned sz, fit, spacing, d;
      longint unsigned pos [8];
      int unsigned n, a;
      bit placed, geo;
      strat_t strat;
      copy_beat_t beat;
      sz = size;
      n = 0;
      placed = 0;
      fit = 0;
      // Too small for one copy plus the reserve.
      if (sz < SPAN + SPARE_RESERVE) begin
        beat.status = STATUS_NO_SPACE;
        beat.idx = '0;
        beat.sector = '0;
        beat.count = '0;
        beat.strat = STRAT_GEOMETRIC;
        beat.last = 1'b1;
        pending_copies.push_back(beat);
        return;
      end
      d = desired;
      if (d == 0) d = 1;
      if (d > COPY_CAP) d = COPY_CAP;
      // Fixed geometric sites, taken in order while they fit.
      for (int i = 0; i < 5; i++) begin
        if (GEO_SITES[i] + SPAN <= sz) begin
          pos[n] = GEO_SITES[i];
          n++;
        end else begin
          break;
        end
      end
      if (n >= FLOOR_COPIES) placed = 1;
      // Evenly spread copies, cut at the first one that overruns.
      if (!placed) begin
        fit = sz / SPAN;
        a = (d * SPAN > sz) ? int'(fit) : int'(d);
        if (a >= FLOOR_COPIES) begin
          spacing = (sz - SPAN) / (a - 1);
          if (spacing < SPAN) spacing = SPAN;
          pos[0] = 0;
          for (int unsigned i = 1; i < a; i++) begin
            pos[i] = i * spacing;
            if (pos[i] + SPAN > sz) begin
              a = i;
              break;
            end
          end
          if (a >= FLOOR_COPIES) begin
            n = a;
            placed = 1;
          end
        end
      end
      // Packed copies as the last resort.
      if (!placed) begin
        n = (fit > d) ? int'(d) : int'(fit);
        for (int unsigned i = 0; i < n; i++) pos[i] = i * SPAN;
      end
      // Name the pattern that the positions follow.
      if (n < 2) begin
        strat = STRAT_MINIMAL;
      end else begin
        geo = 1;
        for (int unsigned i = 0; i < n && i < 5; i++) begin
          if (pos[i] != GEO_SITES[i]) geo = 0;
        end
        if (geo) begin
          strat = STRAT_GEOMETRIC;
        end else begin
          strat = STRAT_LINEAR;
          for (int unsigned i = 2; i < n; i++) begin
            if (pos[i] - pos[i-1] != pos[1] - pos[0]) strat = STRAT_CUSTOM;
          end
        end
      end
      for (int unsigned k = 0; k < n; k++) begin
        beat.status = STATUS_OK;
        beat.idx = k[IDX_W-1:0];
        beat.sector = pos[k][SIZE_W-1:0];
        beat.count = n[CNT_W-1:0];
        beat.strat = strat;
        beat.last = (k + 1 == n);
        pending_copies.push_back(beat);
      end
    endfunction

    function void cmp_field(string fname, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      end
    endfunction

    function void check_copy(logic st, logic [IDX_W-1:0] idx, logic [SIZE_W-1:0] sector,
                             logic [CNT_W-1:0] count, logic [STRAT_W-1:0] strat,
                             logic lst);
      copy_beat_t want;
      if (pending_copies.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual sector %0d index %0d",
                 $time, sector, idx);
        return;
      end
      want = pending_copies.pop_front();
      cmp_field("status", want.status, st);
      cmp_field("copy_index", want.idx, idx);
      cmp_field("copy_sector", want.sector, sector);
      cmp_field("copy_count", want.count, count);
      cmp_field("strategy", want.strat, strat);
      cmp_field("last", want.last, lst);
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SIZE_W-1:0] spare_sectors = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [IDX_W-1:0] copy_index;
  logic [SIZE_W-1:0] copy_sector;
  logic [CNT_W-1:0] copy_count;
  logic [STRAT_W-1:0] strategy;
  logic last;

  bit tx_steady = 0;
  bit rx_steady = 0;
  int stall_left = 0;
  int cycles = 0;
  copy_placement_tracker tracker;

  metadata_copy_placement_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .spare_sectors(spare_sectors),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .copy_index(copy_index), .copy_sector(copy_sector), .copy_count(copy_count),
    .strategy(strategy), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: check each accepted beat, then pick the next ready value.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.check_copy(status, copy_index, copy_sector, copy_count, strategy, last);
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic int tx_gap();
    if (tx_steady) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 0;
      6, 7, 8: return $urandom_range(1, 3);
      default: return $urandom_range(10, 40);
    endcase
  endfunction

  // Mostly sizes around the rule boundaries, some anywhere in 48 bits.
  function automatic logic [SIZE_W-1:0] rand_size();
    logic [63:0] wide;
    longint unsigned edges [5];
    edges = '{72, 1032, 2056, 4104, 8200};
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: return SIZE_W'($urandom_range(0, 71));
      1: return SIZE_W'($urandom_range(60, 90));
      2, 3: return SIZE_W'($urandom_range(72, 1031));
      4: return SIZE_W'(edges[$urandom_range(0, 4)] + $urandom_range(0, 4) - 2);
      5: return SIZE_W'($urandom_range(1032, 9000));
      6, 7: return wide[SIZE_W-1:0];
      8: return SIZE_W'($urandom_range(9000, 1000000));
      default: return SIZE_W'($urandom_range(72, 200));
    endcase
  endfunction

  // Present one size and hold it until the block takes it.
  task automatic send_size(logic [SIZE_W-1:0] size);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    spare_sectors <= size;
    do @(posedge clk); while (!in_ready);
    tracker.note_size(size);
  endtask

  task automatic write_desired(logic [DES_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= DESIRED_ADDR;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tracker.set_desired(value);
  endtask

  task automatic wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [SIZE_W-1:0] directed [$];
    logic [DES_W-1:0] settings [PHASES];
    tracker = new();
    settings = '{4'd5, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd7, 4'd3};
    settings[PHASES-1] = DES_W'($urandom_range(0, 15));
    directed = '{48'd0, 48'd71, 48'd72, 48'd73, 48'd80, 48'd200, 48'd520, 48'd1000,
                 48'd1031, 48'd1032, 48'd2055, 48'd2056, 48'd4103, 48'd4104,
                 48'd8199, 48'd8200, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                 48'h8000_0000_0000, 48'hFFFF_FFFF_FFFF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Boundaries of each rule with the desired count at its reset value.
    foreach (directed[i]) send_size(directed[i]);
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 3 == 1);
      if (ph != 0) write_desired(settings[ph]);
      // A few sizes at the rule boundaries for every setting.
      send_size(48'd72);
      send_size(48'd1031);
      for (int k = 0; k < SIZES_PER_PHASE; k++) begin
        // Hold the sender until all pending copies are out.
        if (ph == 2 && k == 7) begin
          in_valid <= 1'b0;
          wait_drained();
          @(posedge clk);
        end
        send_size(rand_size());
      end
      in_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/mcp_pkg.sv
rtl/mcp_div.sv
rtl/metadata_copy_placement_core.sv
tb/sv/tb_metadata_copy_placement_core.sv
